// File: sv/wwp_pkg.sv
// ----------------------------------------------------------------------------
// wwp_pkg : shared definitions for the weighted work partition unit
// Widths, capacity and the request/response words between the sequencer
// and the shared divider.
// ----------------------------------------------------------------------------
package wwp_pkg;

	// rank capacity of one run
	localparam int MAX_RANKS = 16;

	// fixed field widths
	localparam int WEIGHT_W = 16;
	localparam int WORK_W   = 32;
	localparam int RANK_W   = 4;

	// derived widths
	localparam int IDX_W  = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
	localparam int CNT_W  = $clog2(MAX_RANKS + 1);
	localparam int SUM_W  = WEIGHT_W + IDX_W;
	localparam int PROD_W = WORK_W + WEIGHT_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	// divider request word
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [SUM_W-1:0]  divisor;
	} div_req_t;

	// divider response word
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_LOAD = 5'b00001,
		S_READ = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

endpackage

// File: sv/wwp_ram.sv
// ----------------------------------------------------------------------------
// wwp_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents undefined until
// written.
// ----------------------------------------------------------------------------
module wwp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/wwp_div.sv
// ----------------------------------------------------------------------------
// wwp_div : restoring divider, one quotient bit per cycle
// Divides the product by the weight sum. After start it pulses done
// with the quotient held until the next start.
// ----------------------------------------------------------------------------
module wwp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wwp_pkg::div_req_t req,
	output wwp_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [wwp_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [wwp_pkg::SUM_W-1:0]      rem_q;
	logic [wwp_pkg::SUM_W-1:0]      dsr_q;
	logic [wwp_pkg::PROD_W-1:0]     quo_q;

	logic [wwp_pkg::SUM_W:0]        trial;
	logic [wwp_pkg::SUM_W:0]        diff;
	logic                           ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[wwp_pkg::PROD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	// control: busy flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= wwp_pkg::DIV_CNT_W'(wwp_pkg::PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[wwp_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[wwp_pkg::SUM_W-1:0] : trial[wwp_pkg::SUM_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: sv/weighted_work_partition_unit.sv
// ----------------------------------------------------------------------------
// weighted_work_partition_unit : split total work across ranks by weight
// Collects one speed weight per rank, then emits one share per rank using
// a shared multiplier and a shared bit-serial divider.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  weight   | weight_valid weight_stall weight     | in
//           | last_weight                          |
//  share    | share_valid share_stall rank share   | out
//           | last_share overflow                  |
//  config   | cfg_wr_en cfg_wr_data (work budget)  | in
//
// A weight word without the last flag leaves the unit ready for the next
// word. After the last weight each non-final share passes RAM read,
// multiply, one divider bit per cycle, and output; the final share, or any
// share when the weight sum is zero, goes from RAM read straight to output.
// No clearing pass after reset. A stall on the share channel holds the
// sequencer in the output state; weight_stall is high whenever the unit
// is not loading weights.
// ----------------------------------------------------------------------------
module weighted_work_partition_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_wr_en,
	input  logic [wwp_pkg::WORK_W-1:0]   cfg_wr_data,
	// weight channel
	input  logic                         weight_valid,
	output logic                         weight_stall,
	input  logic [wwp_pkg::WEIGHT_W-1:0] weight,
	input  logic                         last_weight,
	// share channel
	output logic                         share_valid,
	input  logic                         share_stall,
	output logic [wwp_pkg::RANK_W-1:0]   rank,
	output logic [wwp_pkg::WORK_W-1:0]   share,
	output logic                         last_share,
	output logic                         overflow
);

	wwp_pkg::state_t                 state_q;
	logic [wwp_pkg::WORK_W-1:0]      work_budget_q;
	logic [wwp_pkg::CNT_W-1:0]       count_q;
	logic [wwp_pkg::SUM_W-1:0]       sum_q;
	logic                            dropped_q;
	logic [wwp_pkg::IDX_W-1:0]       idx_q;
	logic [wwp_pkg::WORK_W-1:0]      assigned_q;
	logic [wwp_pkg::WORK_W-1:0]      share_q;

	logic                            in_acc;
	logic                            out_acc;
	logic                            has_room;
	logic                            final_rank;
	logic [wwp_pkg::CNT_W-1:0]       idx_next;
	logic [wwp_pkg::IDX_W+wwp_pkg::RANK_W-1:0] idx_ext;
	logic [wwp_pkg::WEIGHT_W-1:0]    rd_weight;
	logic                            ram_re;
	wwp_pkg::div_req_t               div_req;
	wwp_pkg::div_rsp_t               div_rsp;

	// handshakes and rank bookkeeping
	assign in_acc     = weight_valid && !weight_stall;
	assign out_acc    = share_valid && !share_stall;
	assign has_room   = (count_q < wwp_pkg::CNT_W'(wwp_pkg::MAX_RANKS));
	assign idx_next   = wwp_pkg::CNT_W'(idx_q) + 1'b1;
	assign final_rank = (idx_next == count_q);
	assign idx_ext    = {{wwp_pkg::RANK_W{1'b0}}, idx_q};
	assign ram_re     = (state_q == wwp_pkg::S_READ);

	// weight store
	wwp_ram #(
		.WIDTH (wwp_pkg::WEIGHT_W),
		.DEPTH (wwp_pkg::MAX_RANKS)
	) u_store (
		.clk   (clk),
		.we    (in_acc && has_room),
		.waddr (count_q[wwp_pkg::IDX_W-1:0]),
		.wdata (weight),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd_weight)
	);

	// multiply feeds the divider's dividend register
	always_comb begin
		div_req.start    = (state_q == wwp_pkg::S_MUL);
		div_req.dividend = wwp_pkg::PROD_W'(work_budget_q) * wwp_pkg::PROD_W'(rd_weight);
		div_req.divisor  = sum_q;
	end

	wwp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_budget_q <= '0;
		end else if (cfg_wr_en) begin
			work_budget_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wwp_pkg::S_LOAD;
			count_q    <= '0;
			sum_q      <= '0;
			dropped_q  <= 1'b0;
			idx_q      <= '0;
			assigned_q <= '0;
		end else begin
			unique case (state_q)
				wwp_pkg::S_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_q + wwp_pkg::SUM_W'(weight);
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_weight) begin
							idx_q      <= '0;
							assigned_q <= '0;
							state_q    <= wwp_pkg::S_READ;
						end
					end
				end
				wwp_pkg::S_READ: begin
					if (final_rank || sum_q == '0) begin
						state_q <= wwp_pkg::S_OUT;
					end else begin
						state_q <= wwp_pkg::S_MUL;
					end
				end
				wwp_pkg::S_MUL: begin
					state_q <= wwp_pkg::S_DIV;
				end
				wwp_pkg::S_DIV: begin
					if (div_rsp.done) begin
						assigned_q <= assigned_q + div_rsp.quotient[wwp_pkg::WORK_W-1:0];
						state_q    <= wwp_pkg::S_OUT;
					end
				end
				wwp_pkg::S_OUT: begin
					if (out_acc) begin
						if (final_rank) begin
							count_q   <= '0;
							sum_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= wwp_pkg::S_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= wwp_pkg::S_READ;
						end
					end
				end
				default: begin
					state_q <= wwp_pkg::S_LOAD;
				end
			endcase
		end
	end

	// share word register
	always_ff @(posedge clk) begin
		if (state_q == wwp_pkg::S_READ) begin
			if (final_rank) begin
				share_q <= work_budget_q - assigned_q;
			end else begin
				share_q <= '0;
			end
		end else if (state_q == wwp_pkg::S_DIV && div_rsp.done) begin
			share_q <= div_rsp.quotient[wwp_pkg::WORK_W-1:0];
		end
	end

	// outputs
	assign weight_stall = (state_q != wwp_pkg::S_LOAD);
	assign share_valid  = (state_q == wwp_pkg::S_OUT);
	assign rank         = idx_ext[wwp_pkg::RANK_W-1:0];
	assign share        = share_q;
	assign last_share   = final_rank;
	assign overflow     = dropped_q;

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wwp_pkg::CNT_W'(wwp_pkg::MAX_RANKS))
		else $error("rank count above capacity");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wwp_pkg::S_LOAD) |-> (count_q != '0))
		else $error("share phase with no stored rank");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == wwp_pkg::S_DIV))
		else $error("divider finished outside divide state");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_share) |=>
		(state_q == wwp_pkg::S_LOAD && count_q == '0 && sum_q == '0 && !dropped_q))
		else $error("run state not cleared after final share");

	a_zero_sum_share: assert property (@(posedge clk) disable iff (!arst_n)
		(share_valid && !last_share && sum_q == '0) |-> (share == '0))
		else $error("nonzero share with zero weight sum");

endmodule
